FILE: sv/sti_pkg.sv
package sti_pkg;

    localparam int CW = 32;          // coordinate width
    localparam int VW = CW + 1;      // difference vector width
    localparam int WW = 3 * VW + 5;  // triple product width
    localparam int AW = WW + VW;     // accumulator width
    localparam int QW = VW + 2;      // quotient width
    localparam int EW = 16;          // tolerance width
    localparam int NPTS = 5;
    localparam int NSTEP = 24;
    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_EPS = 1'b0;
    localparam logic [EW-1:0] EPS_RESET = 16'd66;

    typedef enum logic [3:0] {
        S_IDLE, S_MATCH, S_VEC, S_MAC_GO, S_MAC_WAIT, S_NORM, S_SUM, S_CHECK,
        S_NUM_GO, S_NUM_WAIT, S_DIV_GO, S_DIV_WAIT, S_OUT
    } st_t;

    typedef enum logic [3:0] {
        V_EX, V_EY, V_EZ, V_E1X, V_E1Y, V_E1Z, V_E2X, V_E2Y, V_E2Z, V_DX, V_DY, V_DZ
    } vsrc_t;

    typedef enum logic [2:0] {
        W_P0, W_P1, W_P2, W_Q0, W_Q1, W_Q2, W_NT
    } wsrc_t;

    typedef enum logic [3:0] {
        D_NONE, D_P0, D_P1, D_P2, D_Q0, D_Q1, D_Q2, D_DET, D_N1, D_N2, D_NT
    } dst_t;

    typedef struct packed {
        logic  a_vec;
        vsrc_t a_v;
        wsrc_t a_w;
        vsrc_t b_v;
        logic  sub;
        logic  first;
        dst_t  dest;
    } ucode_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic sub;
    } mac_cmd_t;

    function automatic ucode_t mk_vv(vsrc_t av, vsrc_t bv, logic sub, logic first,
                                     dst_t dest);
        ucode_t u;
        u.a_vec = 1'b1;
        u.a_v   = av;
        u.a_w   = W_P0;
        u.b_v   = bv;
        u.sub   = sub;
        u.first = first;
        u.dest  = dest;
        return u;
    endfunction

    function automatic ucode_t mk_wv(wsrc_t aw, vsrc_t bv, logic first, dst_t dest);
        ucode_t u;
        u.a_vec = 1'b0;
        u.a_v   = V_EX;
        u.a_w   = aw;
        u.b_v   = bv;
        u.sub   = 1'b0;
        u.first = first;
        u.dest  = dest;
        return u;
    endfunction

    // Program for the cross products P = d x e2, Q = e x e1 and the four dot products.
    function automatic ucode_t sti_ucode(logic [4:0] step);
        ucode_t u;
        unique case (step)
            5'd0:  u = mk_vv(V_DY, V_E2Z, 1'b0, 1'b1, D_NONE);
            5'd1:  u = mk_vv(V_DZ, V_E2Y, 1'b1, 1'b0, D_P0);
            5'd2:  u = mk_vv(V_DZ, V_E2X, 1'b0, 1'b1, D_NONE);
            5'd3:  u = mk_vv(V_DX, V_E2Z, 1'b1, 1'b0, D_P1);
            5'd4:  u = mk_vv(V_DX, V_E2Y, 1'b0, 1'b1, D_NONE);
            5'd5:  u = mk_vv(V_DY, V_E2X, 1'b1, 1'b0, D_P2);
            5'd6:  u = mk_vv(V_EY, V_E1Z, 1'b0, 1'b1, D_NONE);
            5'd7:  u = mk_vv(V_EZ, V_E1Y, 1'b1, 1'b0, D_Q0);
            5'd8:  u = mk_vv(V_EZ, V_E1X, 1'b0, 1'b1, D_NONE);
            5'd9:  u = mk_vv(V_EX, V_E1Z, 1'b1, 1'b0, D_Q1);
            5'd10: u = mk_vv(V_EX, V_E1Y, 1'b0, 1'b1, D_NONE);
            5'd11: u = mk_vv(V_EY, V_E1X, 1'b1, 1'b0, D_Q2);
            5'd12: u = mk_wv(W_P0, V_E1X, 1'b1, D_NONE);
            5'd13: u = mk_wv(W_P1, V_E1Y, 1'b0, D_NONE);
            5'd14: u = mk_wv(W_P2, V_E1Z, 1'b0, D_DET);
            5'd15: u = mk_wv(W_P0, V_EX, 1'b1, D_NONE);
            5'd16: u = mk_wv(W_P1, V_EY, 1'b0, D_NONE);
            5'd17: u = mk_wv(W_P2, V_EZ, 1'b0, D_N1);
            5'd18: u = mk_wv(W_Q0, V_DX, 1'b1, D_NONE);
            5'd19: u = mk_wv(W_Q1, V_DY, 1'b0, D_NONE);
            5'd20: u = mk_wv(W_Q2, V_DZ, 1'b0, D_N2);
            5'd21: u = mk_wv(W_Q0, V_E2X, 1'b1, D_NONE);
            5'd22: u = mk_wv(W_Q1, V_E2Y, 1'b0, D_NONE);
            5'd23: u = mk_wv(W_Q2, V_E2Z, 1'b0, D_NT);
            default: u = mk_wv(W_P0, V_EX, 1'b1, D_NONE);
        endcase
        return u;
    endfunction

endpackage

FILE: sv/segment_triangle_intersection_top.sv
// Loads of point slots 0 to 3 are stored while idle, and the block stays ready for the next load.
// A slot 4 load runs the test: after the item is accepted the block runs the vertex match
// checks, 24 multiply-accumulate passes, and per axis a multiply and a division, then
// registers the result; a miss ends earlier. The next item is taken once the result is in
// the output register.
// Synchronous reset (aresetn low) zeroes the stored points, sets the tolerance to 66 and idles.
module segment_triangle_intersection_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [95:0]                    s_tdata,  // coord_x, coord_y, coord_z
    input  logic [2:0]                     s_tuser,  // point_slot
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [95:0]                    m_tdata,  // exact_x, exact_y, exact_z
    output logic                           m_tuser,  // hit
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sti_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int CW = sti_pkg::CW;
    localparam int VW = sti_pkg::VW;
    localparam int WW = sti_pkg::WW;
    localparam int AW = sti_pkg::AW;
    localparam int QW = sti_pkg::QW;
    localparam int EW = sti_pkg::EW;

    sti_pkg::st_t state_reg, state_next;

    logic [EW-1:0]          eps_reg;
    logic signed [CW-1:0]   px_reg [sti_pkg::NPTS];
    logic signed [CW-1:0]   py_reg [sti_pkg::NPTS];
    logic signed [CW-1:0]   pz_reg [sti_pkg::NPTS];
    logic signed [VW-1:0]   e_reg  [3];
    logic signed [VW-1:0]   e1_reg [3];
    logic signed [VW-1:0]   e2_reg [3];
    logic signed [VW-1:0]   d_reg  [3];
    logic signed [WW-1:0]   p_reg  [3];
    logic signed [WW-1:0]   q_reg  [3];
    logic signed [WW-1:0]   det_reg, n1_reg, n2_reg, nt_reg;
    logic signed [WW:0]     sum_reg;
    logic signed [CW-1:0]   res_reg [3];
    logic [4:0]             step_reg;
    logic [1:0]             cnt_reg;
    logic                   neg_reg;

    logic                   m_tvalid_reg;
    logic                   m_hit_reg;
    logic [3*CW-1:0]        m_data_reg;

    logic                   s_acc;
    logic                   out_free;
    logic                   cfg_wr;
    sti_pkg::ucode_t        uc;
    sti_pkg::mac_cmd_t      mac_cmd;
    logic signed [WW-1:0]   mac_a;
    logic signed [VW-1:0]   mac_b;
    logic                   mac_done;
    logic signed [AW-1:0]   mac_acc;
    logic signed [AW-1:0]   acc_mag;
    logic                   div_start;
    logic                   div_done;
    logic [QW-1:0]          div_q;
    logic [2:0]             vidx;
    logic                   vclose;
    logic                   det_zero;
    logic                   bad;
    logic signed [CW+3:0]   res_sum;
    logic signed [CW+3:0]   qs;

    function automatic logic near(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                  logic [EW-1:0] eps);
        logic signed [VW-1:0] diff;
        logic [VW-1:0]        mag;
        diff = {a[CW-1], a} - {b[CW-1], b};
        mag  = diff[VW-1] ? VW'(-diff) : VW'(diff);
        return mag < {{(VW - EW){1'b0}}, eps};
    endfunction

    function automatic logic signed [VW-1:0] vsel(sti_pkg::vsrc_t s,
            logic signed [VW-1:0] e0, logic signed [VW-1:0] e1v,
            logic signed [VW-1:0] e2v, logic signed [VW-1:0] ex1,
            logic signed [VW-1:0] ey1, logic signed [VW-1:0] ez1,
            logic signed [VW-1:0] ex2, logic signed [VW-1:0] ey2,
            logic signed [VW-1:0] ez2, logic signed [VW-1:0] dx,
            logic signed [VW-1:0] dy, logic signed [VW-1:0] dz);
        logic signed [VW-1:0] r;
        unique case (s)
            sti_pkg::V_EX:  r = e0;
            sti_pkg::V_EY:  r = e1v;
            sti_pkg::V_EZ:  r = e2v;
            sti_pkg::V_E1X: r = ex1;
            sti_pkg::V_E1Y: r = ey1;
            sti_pkg::V_E1Z: r = ez1;
            sti_pkg::V_E2X: r = ex2;
            sti_pkg::V_E2Y: r = ey2;
            sti_pkg::V_E2Z: r = ez2;
            sti_pkg::V_DX:  r = dx;
            sti_pkg::V_DY:  r = dy;
            sti_pkg::V_DZ:  r = dz;
            default:        r = '0;
        endcase
        return r;
    endfunction

    assign s_tready = (state_reg == sti_pkg::S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = m_data_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == sti_pkg::REG_EPS);
    assign prdata = (paddr[2:2] == sti_pkg::REG_EPS) ? {{(32 - EW){1'b0}}, eps_reg} : '0;

    assign uc   = sti_pkg::sti_ucode(step_reg);
    assign vidx = 3'(cnt_reg) + 3'd2;
    assign vclose =
        (near(px_reg[0], px_reg[vidx], eps_reg) && near(py_reg[0], py_reg[vidx], eps_reg) &&
         near(pz_reg[0], pz_reg[vidx], eps_reg)) ||
        (near(px_reg[1], px_reg[vidx], eps_reg) && near(py_reg[1], py_reg[vidx], eps_reg) &&
         near(pz_reg[1], pz_reg[vidx], eps_reg));

    assign det_zero = (det_reg == '0);
    assign bad = n1_reg[WW-1] || n2_reg[WW-1] || nt_reg[WW-1] ||
                 (sum_reg > {det_reg[WW-1], det_reg}) || (nt_reg > det_reg);

    assign acc_mag = mac_acc[AW-1] ? -mac_acc : mac_acc;
    assign qs      = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    always_comb begin
        res_sum = qs + CW'(0);
        unique case (cnt_reg)
            2'd0:    res_sum = {{4{px_reg[0][CW-1]}}, px_reg[0]} + qs;
            2'd1:    res_sum = {{4{py_reg[0][CW-1]}}, py_reg[0]} + qs;
            default: res_sum = {{4{pz_reg[0][CW-1]}}, pz_reg[0]} + qs;
        endcase
    end

    always_comb begin
        mac_b = vsel(uc.b_v, e_reg[0], e_reg[1], e_reg[2], e1_reg[0], e1_reg[1], e1_reg[2],
                     e2_reg[0], e2_reg[1], e2_reg[2], d_reg[0], d_reg[1], d_reg[2]);
        if (uc.a_vec) begin
            mac_a = WW'(vsel(uc.a_v, e_reg[0], e_reg[1], e_reg[2], e1_reg[0], e1_reg[1],
                             e1_reg[2], e2_reg[0], e2_reg[1], e2_reg[2], d_reg[0],
                             d_reg[1], d_reg[2]));
        end else begin
            unique case (uc.a_w)
                sti_pkg::W_P0: mac_a = p_reg[0];
                sti_pkg::W_P1: mac_a = p_reg[1];
                sti_pkg::W_P2: mac_a = p_reg[2];
                sti_pkg::W_Q0: mac_a = q_reg[0];
                sti_pkg::W_Q1: mac_a = q_reg[1];
                sti_pkg::W_Q2: mac_a = q_reg[2];
                default:       mac_a = nt_reg;
            endcase
        end
        if (state_reg == sti_pkg::S_NUM_GO) begin
            mac_a = nt_reg;
            mac_b = d_reg[cnt_reg];
        end
    end

    always_comb begin
        state_next    = state_reg;
        mac_cmd.start = 1'b0;
        mac_cmd.clear = uc.first;
        mac_cmd.sub   = uc.sub;
        div_start     = 1'b0;
        unique case (state_reg)
            sti_pkg::S_IDLE: begin
                if (s_acc && s_tuser == 3'(sti_pkg::NPTS - 1)) begin
                    state_next = sti_pkg::S_MATCH;
                end
            end
            sti_pkg::S_MATCH: begin
                if (vclose) begin
                    state_next = sti_pkg::S_OUT;
                end else if (cnt_reg == 2'd2) begin
                    state_next = sti_pkg::S_VEC;
                end
            end
            sti_pkg::S_VEC: state_next = sti_pkg::S_MAC_GO;
            sti_pkg::S_MAC_GO: begin
                mac_cmd.start = 1'b1;
                state_next    = sti_pkg::S_MAC_WAIT;
            end
            sti_pkg::S_MAC_WAIT: begin
                if (mac_done) begin
                    state_next = (step_reg == 5'(sti_pkg::NSTEP - 1)) ?
                                 sti_pkg::S_NORM : sti_pkg::S_MAC_GO;
                end
            end
            sti_pkg::S_NORM: state_next = det_zero ? sti_pkg::S_OUT : sti_pkg::S_SUM;
            sti_pkg::S_SUM:  state_next = sti_pkg::S_CHECK;
            sti_pkg::S_CHECK: state_next = bad ? sti_pkg::S_OUT : sti_pkg::S_NUM_GO;
            sti_pkg::S_NUM_GO: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clear = 1'b1;
                mac_cmd.sub   = 1'b0;
                state_next    = sti_pkg::S_NUM_WAIT;
            end
            sti_pkg::S_NUM_WAIT: begin
                if (mac_done) begin
                    state_next = sti_pkg::S_DIV_GO;
                end
            end
            sti_pkg::S_DIV_GO: begin
                div_start  = 1'b1;
                state_next = sti_pkg::S_DIV_WAIT;
            end
            sti_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (cnt_reg == 2'd2) ? sti_pkg::S_OUT : sti_pkg::S_NUM_GO;
                end
            end
            sti_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = sti_pkg::S_IDLE;
                end
            end
            default: state_next = sti_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sti_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg      <= sti_pkg::EPS_RESET;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < sti_pkg::NPTS; i++) begin
                px_reg[i] <= '0;
                py_reg[i] <= '0;
                pz_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                eps_reg <= pwdata[EW-1:0];
            end
            if (state_reg == sti_pkg::S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                sti_pkg::S_IDLE: begin
                    if (s_acc && s_tuser < 3'(sti_pkg::NPTS)) begin
                        px_reg[s_tuser] <= s_tdata[CW-1:0];
                        py_reg[s_tuser] <= s_tdata[2*CW-1:CW];
                        pz_reg[s_tuser] <= s_tdata[3*CW-1:2*CW];
                    end
                    cnt_reg <= '0;
                    for (int i = 0; i < 3; i++) begin
                        res_reg[i] <= '0;
                    end
                end
                sti_pkg::S_MATCH: begin
                    if (!vclose) begin
                        cnt_reg <= cnt_reg + 2'd1;
                    end
                end
                sti_pkg::S_VEC: begin
                    e_reg[0]  <= {px_reg[0][CW-1], px_reg[0]} - {px_reg[2][CW-1], px_reg[2]};
                    e_reg[1]  <= {py_reg[0][CW-1], py_reg[0]} - {py_reg[2][CW-1], py_reg[2]};
                    e_reg[2]  <= {pz_reg[0][CW-1], pz_reg[0]} - {pz_reg[2][CW-1], pz_reg[2]};
                    e1_reg[0] <= {px_reg[3][CW-1], px_reg[3]} - {px_reg[2][CW-1], px_reg[2]};
                    e1_reg[1] <= {py_reg[3][CW-1], py_reg[3]} - {py_reg[2][CW-1], py_reg[2]};
                    e1_reg[2] <= {pz_reg[3][CW-1], pz_reg[3]} - {pz_reg[2][CW-1], pz_reg[2]};
                    e2_reg[0] <= {px_reg[4][CW-1], px_reg[4]} - {px_reg[2][CW-1], px_reg[2]};
                    e2_reg[1] <= {py_reg[4][CW-1], py_reg[4]} - {py_reg[2][CW-1], py_reg[2]};
                    e2_reg[2] <= {pz_reg[4][CW-1], pz_reg[4]} - {pz_reg[2][CW-1], pz_reg[2]};
                    d_reg[0]  <= {px_reg[1][CW-1], px_reg[1]} - {px_reg[0][CW-1], px_reg[0]};
                    d_reg[1]  <= {py_reg[1][CW-1], py_reg[1]} - {py_reg[0][CW-1], py_reg[0]};
                    d_reg[2]  <= {pz_reg[1][CW-1], pz_reg[1]} - {pz_reg[0][CW-1], pz_reg[0]};
                    step_reg  <= '0;
                    cnt_reg   <= '0;
                end
                sti_pkg::S_MAC_WAIT: begin
                    if (mac_done) begin
                        step_reg <= step_reg + 5'd1;
                        unique case (uc.dest)
                            sti_pkg::D_P0:  p_reg[0] <= mac_acc[WW-1:0];
                            sti_pkg::D_P1:  p_reg[1] <= mac_acc[WW-1:0];
                            sti_pkg::D_P2:  p_reg[2] <= mac_acc[WW-1:0];
                            sti_pkg::D_Q0:  q_reg[0] <= mac_acc[WW-1:0];
                            sti_pkg::D_Q1:  q_reg[1] <= mac_acc[WW-1:0];
                            sti_pkg::D_Q2:  q_reg[2] <= mac_acc[WW-1:0];
                            sti_pkg::D_DET: det_reg  <= mac_acc[WW-1:0];
                            sti_pkg::D_N1:  n1_reg   <= mac_acc[WW-1:0];
                            sti_pkg::D_N2:  n2_reg   <= mac_acc[WW-1:0];
                            sti_pkg::D_NT:  nt_reg   <= mac_acc[WW-1:0];
                            default: ;
                        endcase
                    end
                end
                sti_pkg::S_NORM: begin
                    // Make the determinant positive so all tests compare against it directly.
                    if (det_reg[WW-1]) begin
                        det_reg <= -det_reg;
                        n1_reg  <= -n1_reg;
                        n2_reg  <= -n2_reg;
                        nt_reg  <= -nt_reg;
                    end
                end
                sti_pkg::S_SUM: begin
                    sum_reg <= {n1_reg[WW-1], n1_reg} + {n2_reg[WW-1], n2_reg};
                    cnt_reg <= '0;
                end
                sti_pkg::S_DIV_GO: neg_reg <= mac_acc[AW-1];
                sti_pkg::S_DIV_WAIT: begin
                    if (div_done) begin
                        res_reg[cnt_reg] <= res_sum[CW-1:0];
                        cnt_reg          <= cnt_reg + 2'd1;
                    end
                end
                sti_pkg::S_OUT: begin
                    if (out_free) begin
                        m_hit_reg <= (cnt_reg == 2'd3);
                        if (cnt_reg == 2'd3) begin
                            m_data_reg <= {res_reg[2], res_reg[1], res_reg[0]};
                        end else begin
                            m_data_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    sti_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .a       (mac_a),
        .b       (mac_b),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    sti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_mag[AW-2:0]),
        .den     (det_reg[WW-2:0]),
        .done    (div_done),
        .quo     (div_q)
    );

endmodule

FILE: sv/sti_mac.sv
module sti_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sti_pkg::mac_cmd_t             cmd,
    input  logic signed [sti_pkg::WW-1:0] a,
    input  logic signed [sti_pkg::VW-1:0] b,
    output logic                          done,
    output logic signed [sti_pkg::AW-1:0] acc
);

    logic signed [sti_pkg::AW-1:0] acc_reg;
    logic signed [sti_pkg::AW-1:0] ash_reg;
    logic [sti_pkg::VW-1:0]        bsh_reg;
    logic [5:0]                    cnt_reg;
    logic                          run_reg;
    logic                          done_reg;
    logic                          sub_reg;
    logic                          last;

    assign last = (cnt_reg == 6'(sti_pkg::VW - 1));
    assign done = done_reg;
    assign acc  = acc_reg;

    // Shift-add over the bits of b; the top bit of b carries negative weight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                ash_reg <= {{(sti_pkg::AW - sti_pkg::WW){a[sti_pkg::WW-1]}}, a};
                bsh_reg <= b;
                cnt_reg <= '0;
                sub_reg <= cmd.sub;
                run_reg <= 1'b1;
                if (cmd.clear) begin
                    acc_reg <= '0;
                end
            end else if (run_reg) begin
                if (bsh_reg[0]) begin
                    if (sub_reg ^ last) begin
                        acc_reg <= acc_reg - ash_reg;
                    end else begin
                        acc_reg <= acc_reg + ash_reg;
                    end
                end
                ash_reg <= ash_reg <<< 1;
                bsh_reg <= bsh_reg >> 1;
                cnt_reg <= cnt_reg + 6'd1;
                if (last) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: sv/sti_div.sv
module sti_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [sti_pkg::AW-2:0]   num,
    input  logic [sti_pkg::WW-2:0]   den,
    output logic                     done,
    output logic [sti_pkg::QW-1:0]   quo
);

    logic [sti_pkg::AW-1:0] rem_reg;
    logic [sti_pkg::AW-1:0] dsh_reg;
    logic [sti_pkg::WW-2:0] den_reg;
    logic [sti_pkg::QW-1:0] q_reg;
    logic [5:0]             cnt_reg;
    logic                   run_reg;
    logic                   done_reg;
    logic                   ge;
    logic                   round_up;

    assign ge       = (rem_reg >= dsh_reg);
    assign round_up = ({rem_reg, 1'b0} >= {{(sti_pkg::AW - sti_pkg::WW + 2){1'b0}}, den_reg});
    assign done     = done_reg;
    assign quo      = q_reg;

    // Restoring division, one quotient bit a cycle, then round half away from zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg <= {1'b0, num};
                dsh_reg <= {den, {(sti_pkg::QW - 1){1'b0}}};
                den_reg <= den;
                q_reg   <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (cnt_reg == 6'(sti_pkg::QW)) begin
                    q_reg    <= q_reg + {{(sti_pkg::QW - 1){1'b0}}, round_up};
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    if (ge) begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    q_reg   <= {q_reg[sti_pkg::QW-2:0], ge};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
        end
    end

endmodule
